// File: design/swvm_pkg.sv
package swvm_pkg;

    localparam int DEPTH        = 32;
    localparam int CHANNELS     = 3;
    localparam int SAMPLE_WIDTH = 16;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int CFG_W   = 6;
    localparam int IDX_W   = 5;
    localparam int FILL_W  = 6;
    localparam int WORD_W  = CHANNELS * SAMPLE_WIDTH;
    localparam int SUM_W   = SAMPLE_WIDTH + ADDR_W + 1;
    localparam int LANES   = CHANNELS + 1;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(32);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_UPDATE,
        S_LOAD,
        S_DIVIDE,
        S_RD_ENTRY,
        S_OUTPUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_x;
        logic signed [SAMPLE_WIDTH-1:0] sample_y;
        logic signed [SAMPLE_WIDTH-1:0] sample_z;
        logic        [IDX_W-1:0]        read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] entry_x;
        logic signed [SAMPLE_WIDTH-1:0] entry_y;
        logic signed [SAMPLE_WIDTH-1:0] entry_z;
        logic                           index_in_fill;
        logic        [FILL_W-1:0]       fill_count;
        logic signed [SAMPLE_WIDTH-1:0] mean_x;
        logic signed [SAMPLE_WIDTH-1:0] mean_y;
        logic signed [SAMPLE_WIDTH-1:0] mean_z;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic rd_old;
        logic update;
        logic load_div;
        logic div_step;
        logic rd_entry;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

// File: design/swvm_in_if.sv
interface swvm_in_if;
    import swvm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/swvm_out_if.sv
interface swvm_out_if;
    import swvm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/swvm_ram.sv
module swvm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/swvm_ctrl.sv
module swvm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  swvm_pkg::t_dp_sts   i_sts,
    output swvm_pkg::t_ctrl_cmd o_cmd
);
    import swvm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD:   n_state = S_UPDATE;
            S_UPDATE:   n_state = S_LOAD;
            S_LOAD:     n_state = S_DIVIDE;
            S_DIVIDE: begin
                if (i_sts.div_last) begin
                    n_state = S_RD_ENTRY;
                end
            end
            S_RD_ENTRY: n_state = S_OUTPUT;
            S_OUTPUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_RD_OLD:   o_cmd.rd_old   = 1'b1;
            S_UPDATE:   o_cmd.update   = 1'b1;
            S_LOAD:     o_cmd.load_div = 1'b1;
            S_DIVIDE:   o_cmd.div_step = 1'b1;
            S_RD_ENTRY: o_cmd.rd_entry = 1'b1;
            S_OUTPUT:   o_cmd.load_out = out_free;
            default:    o_cmd          = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// File: design/swvm_datapath.sv
module swvm_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [5:0]             i_cfg_wdata,
    input  swvm_pkg::t_in_item     i_in_data,
    input  swvm_pkg::t_ctrl_cmd    i_cmd,
    output swvm_pkg::t_dp_sts      o_sts,
    output swvm_pkg::t_out_item    o_out_data
);
    import swvm_pkg::*;

    logic [CFG_W-1:0]               r_cfg;
    logic [ADDR_W-1:0]              r_oldest, n_oldest;
    logic [LEN_W-1:0]               r_held, n_held;
    logic [DEPTH-1:0]               r_slot_valid;
    logic                           r_rd_valid;
    logic [ADDR_W-1:0]              r_wpos, n_wpos;
    logic signed [SAMPLE_WIDTH-1:0] r_smp [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] in_smp [CHANNELS];
    logic [IDX_W-1:0]               r_idx;
    logic signed [SUM_W-1:0]        r_sum [CHANNELS];
    logic [SUM_W-1:0]               r_quo [LANES];
    logic [LEN_W-1:0]               r_rem [LANES];
    logic [CHANNELS-1:0]            r_neg;
    logic [STEP_W-1:0]              r_step;
    t_out_item                      r_out;

    logic [LEN_W-1:0]  len;
    logic              full;
    logic [LEN_W:0]    wsum;
    logic [LEN_W-1:0]  old_inc;
    logic [LEN_W:0]    rsum;
    logic [ADDR_W-1:0] rpos;
    logic [LEN_W-1:0]  off;
    logic [ADDR_W-1:0] raddr;
    logic              re;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] wdata;
    logic signed [SAMPLE_WIDTH-1:0] rd_smp [CHANNELS];
    logic [LEN_W:0]    rem_sh [LANES];
    logic              ge [LANES];
    logic [SUM_W-1:0]  mean_w [CHANNELS];

    assign in_smp[0] = i_in_data.sample_x;
    assign in_smp[1] = i_in_data.sample_y;
    assign in_smp[2] = i_in_data.sample_z;

    always_comb begin
        if (r_cfg == '0) begin
            len = LEN_W'(1);
        end else if (int'(r_cfg) > DEPTH) begin
            len = LEN_W'(DEPTH);
        end else begin
            len = LEN_W'(r_cfg);
        end
    end

    assign full    = (r_held == len);
    assign wsum    = (LEN_W + 1)'(r_oldest) + (LEN_W + 1)'(r_held);
    assign old_inc = LEN_W'(r_oldest) + LEN_W'(1);

    always_comb begin
        n_wpos   = r_oldest;
        n_oldest = r_oldest;
        n_held   = r_held;
        if (full) begin
            n_oldest = (old_inc == len) ? '0 : ADDR_W'(old_inc);
        end else begin
            n_wpos = (wsum >= (LEN_W + 1)'(len)) ? ADDR_W'(wsum - (LEN_W + 1)'(len))
                                                  : ADDR_W'(wsum);
            n_held = r_held + LEN_W'(1);
        end
    end

    assign off  = r_rem[CHANNELS];
    assign rsum = (LEN_W + 1)'(off) + (LEN_W + 1)'(r_oldest);
    assign rpos = (rsum >= (LEN_W + 1)'(len)) ? ADDR_W'(rsum - (LEN_W + 1)'(len))
                                              : ADDR_W'(rsum);

    assign re    = i_cmd.rd_old | i_cmd.rd_entry;
    assign raddr = i_cmd.rd_old ? r_wpos : rpos;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            wdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_smp[c];
            rd_smp[c] = r_rd_valid ? $signed(rdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH]) : '0;
            mean_w[c] = r_neg[c] ? (SUM_W'(0) - r_quo[c]) : r_quo[c];
        end
        for (int l = 0; l < LANES; l++) begin
            rem_sh[l] = {r_rem[l], r_quo[l][SUM_W-1]};
            ge[l]     = (rem_sh[l] >= (LEN_W + 1)'(len));
        end
    end

    swvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_wpos),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= CFG_RESET;
            r_oldest     <= '0;
            r_held       <= '0;
            r_slot_valid <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg        <= i_cfg_wdata;
            r_oldest     <= '0;
            r_held       <= '0;
            r_slot_valid <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_oldest <= n_oldest;
                r_held   <= n_held;
            end
            if (i_cmd.update) begin
                r_slot_valid[r_wpos] <= 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(r_smp[c]) - SUM_W'(rd_smp[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wpos <= n_wpos;
            r_idx  <= i_in_data.read_index;
            for (int c = 0; c < CHANNELS; c++) begin
                r_smp[c] <= in_smp[c];
            end
        end
        if (re) begin
            r_rd_valid <= r_slot_valid[raddr];
        end
        if (i_cmd.load_div) begin
            r_step <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_neg[c] <= r_sum[c][SUM_W-1];
                r_quo[c] <= r_sum[c][SUM_W-1] ? (SUM_W'(0) - r_sum[c]) : r_sum[c];
                r_rem[c] <= '0;
            end
            r_quo[CHANNELS] <= SUM_W'(r_idx);
            r_rem[CHANNELS] <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
            for (int l = 0; l < LANES; l++) begin
                r_quo[l] <= {r_quo[l][SUM_W-2:0], ge[l]};
                r_rem[l] <= ge[l] ? LEN_W'(rem_sh[l] - (LEN_W + 1)'(len))
                                  : LEN_W'(rem_sh[l]);
            end
        end
        if (i_cmd.load_out) begin
            r_out.entry_x       <= rd_smp[0];
            r_out.entry_y       <= rd_smp[1];
            r_out.entry_z       <= rd_smp[2];
            r_out.index_in_fill <= (off < r_held);
            r_out.fill_count    <= FILL_W'(r_held);
            r_out.mean_x        <= SAMPLE_WIDTH'(mean_w[0]);
            r_out.mean_y        <= SAMPLE_WIDTH'(mean_w[1]);
            r_out.mean_z        <= SAMPLE_WIDTH'(mean_w[2]);
        end
    end

    assign o_sts.div_last = (r_step == STEP_LAST);
    assign o_out_data     = r_out;
endmodule

// File: design/sliding_window_vector_mean_core.sv
// Sliding-window mean of three-channel signed Q8.8 samples. Each item pushes one
// sample into a ring window of window_length slots (0 acts as 1, above 32 as 32)
// and returns the entry at read_index mod window_length past the oldest, the fill
// count and the per-channel mean, truncated toward zero. An accepted item passes
// the old-entry read, update, divider load, restoring divide (one quotient bit
// per cycle) running the three channel means and the offset reduction side by
// side, entry read and output load. Input ready is high only between items. A
// finished result waits in the output register while the next item is taken.
// Writing window_length empties the window; write it only while the block is idle.
module sliding_window_vector_mean_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    swvm_in_if.sink    i_in,
    swvm_out_if.source o_out
);
    import swvm_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    swvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    swvm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out.data)
    );
endmodule

// File: dv/swvm_mean_checker.sv
module swvm_mean_checker
    import swvm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    swvm_in_if               i_in,
    swvm_out_if              i_out,
    output int               o_err_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    int               slot_val [DEPTH][CHANNELS];
    int               oldest_pos;
    int               held_cnt;
    int               chan_sum [CHANNELS];
    logic [CFG_W-1:0] win_len_reg;
    t_out_item        pending_results [$];
    int               err_n = 0;

    task automatic clear_window();
        foreach (slot_val[i, c]) slot_val[i][c] = 0;
        foreach (chan_sum[c]) chan_sum[c] = 0;
        oldest_pos = 0;
        held_cnt   = 0;
    endtask

    task automatic push_sample(input t_in_item it, output t_out_item r);
        int len;
        int wpos;
        int rpos;
        int off;
        int smp [CHANNELS];
        int ent [CHANNELS];
        int avg [CHANNELS];
        smp[0] = it.sample_x;
        smp[1] = it.sample_y;
        smp[2] = it.sample_z;
        if (win_len_reg == '0) begin
            len = 1;
        end else if (win_len_reg > DEPTH) begin
            len = DEPTH;
        end else begin
            len = int'(win_len_reg);
        end
        if (held_cnt > len) held_cnt = len;
        if (oldest_pos >= len) oldest_pos = 0;
        // full window: overwrite the oldest and advance
        if (held_cnt == len) begin
            wpos       = oldest_pos;
            oldest_pos = (oldest_pos + 1) % len;
        end else begin
            wpos     = (oldest_pos + held_cnt) % len;
            held_cnt = held_cnt + 1;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            chan_sum[c]       = chan_sum[c] + smp[c] - slot_val[wpos][c];
            slot_val[wpos][c] = smp[c];
        end
        off  = int'(it.read_index) % len;
        rpos = (off + oldest_pos) % len;
        for (int c = 0; c < CHANNELS; c++) begin
            ent[c] = slot_val[rpos][c];
            avg[c] = chan_sum[c] / len;
        end
        r.entry_x       = 16'(ent[0]);
        r.entry_y       = 16'(ent[1]);
        r.entry_z       = 16'(ent[2]);
        r.index_in_fill = (off < held_cnt);
        r.fill_count    = FILL_W'(held_cnt);
        r.mean_x        = 16'(avg[0]);
        r.mean_y        = 16'(avg[1]);
        r.mean_z        = 16'(avg[2]);
    endtask

    task automatic report_error(input string msg);
        $display("%0t swvm mismatch: %s", $time, msg);
        err_n++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            clear_window();
            win_len_reg = CFG_RESET;
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    report_error("result with no item outstanding");
                end else begin
                    want = pending_results.pop_front();
                    check_field("entry_x", i_out.data.entry_x, want.entry_x);
                    check_field("entry_y", i_out.data.entry_y, want.entry_y);
                    check_field("entry_z", i_out.data.entry_z, want.entry_z);
                    check_field("index_in_fill", i_out.data.index_in_fill,
                                want.index_in_fill);
                    check_field("fill_count", i_out.data.fill_count, want.fill_count);
                    check_field("mean_x", i_out.data.mean_x, want.mean_x);
                    check_field("mean_y", i_out.data.mean_y, want.mean_y);
                    check_field("mean_z", i_out.data.mean_z, want.mean_z);
                end
            end
            if (i_cfg_we) begin
                win_len_reg = i_cfg_wdata;
                clear_window();
            end
            if (i_in.valid && i_in.ready) begin
                push_sample(i_in.data, pred);
                pending_results.push_back(pred);
            end
        end
        o_err_count <= err_n;
        o_pending   <= pending_results.size();
    end

endmodule

// File: dv/sliding_window_vector_mean_core_tb.sv
module sliding_window_vector_mean_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swvm_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES    = 30;
    localparam int N_PHASES        = 11;
    localparam logic [CFG_W-1:0] PHASE_LEN [N_PHASES] = '{
        6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd2, 6'd31, 6'd16, 6'd33, 6'd5, 6'd32
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               err_count;
    int               pending;
    logic             gaps_on;
    logic             hold_req;

    swvm_in_if  in_ch ();
    swvm_out_if out_ch ();

    sliding_window_vector_mean_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    swvm_mean_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_in_item mk_item(input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] z, input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.sample_x   = x;
        it.sample_y   = y;
        it.sample_z   = z;
        it.read_index = idx;
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while (gaps_on && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(input logic [CFG_W-1:0] v);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        t_in_item it;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        gaps_on     <= 1'b1;
        hold_req    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk_item(16'h7FFF, 16'h8000, 16'h0000, 5'd0));
        send_item(mk_item(16'h8000, 16'h7FFF, 16'hFFFF, 5'd31));
        send_item(mk_item(16'hFFFF, 16'h0001, 16'h7FFF, 5'd1));
        send_item(mk_item(16'h0100, 16'hFF00, 16'h0080, 5'd2));
        send_item(mk_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd3));
        send_item(mk_item(16'h8000, 16'h8000, 16'h8000, 5'd4));
        write_len(6'd3);
        send_item(mk_item(16'h7FFF, 16'h8000, 16'h0001, 5'd0));
        send_item(mk_item(16'h8000, 16'h7FFF, 16'hFFFF, 5'd2));
        send_item(mk_item(16'h0005, 16'hFFFB, 16'h0003, 5'd31));
        send_item(mk_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd1));
        send_item(mk_item(16'h0007, 16'hFFF9, 16'h0000, 5'd5));
        write_len(6'd0);
        send_item(mk_item(16'h7FFF, 16'h8000, 16'hFFFF, 5'd31));
        send_item(mk_item(16'h8000, 16'h7FFF, 16'h0001, 5'd0));
        send_item(mk_item(16'h0003, 16'hFFFD, 16'h0000, 5'd17));
        write_len(6'd63);
        send_item(mk_item(16'h7FFF, 16'h8000, 16'hFFFF, 5'd31));
        send_item(mk_item(16'hFFFF, 16'h0001, 16'h0000, 5'd0));
        send_item(mk_item(16'h1234, 16'hEDCC, 16'h8000, 5'd30));

        for (int p = 0; p < N_PHASES; p++) begin
            write_len(PHASE_LEN[p]);
            gaps_on <= (p != 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                hold_req <= ((p == 0 || p == 7) && n == 20);
                it.sample_x   = rand_sample();
                it.sample_y   = rand_sample();
                it.sample_z   = rand_sample();
                it.read_index = IDX_W'($urandom);
                send_item(it);
            end
        end

        wait_drain();
        if (err_count == 0) begin
            $display("sliding_window_vector_mean_core_tb: done, clean");
        end else begin
            $display("sliding_window_vector_mean_core_tb: done, errors");
        end
        $finish;
    end

    // hold off the receiver on request so the block backs up into its input
    initial begin
        int   hold_left;
        logic hold_prev;
        hold_left = 0;
        hold_prev = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_prev) begin
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
            end
            hold_prev = hold_req;
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("sliding_window_vector_mean_core_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
design/swvm_pkg.sv
design/swvm_in_if.sv
design/swvm_out_if.sv
design/swvm_ram.sv
design/swvm_ctrl.sv
design/swvm_datapath.sv
design/sliding_window_vector_mean_core.sv
dv/swvm_mean_checker.sv
dv/sliding_window_vector_mean_core_tb.sv
